// File: rtl/core/fpa_pkg.sv
// Shared types and constants of the fixed-point two's complement ALU.
package fpa_pkg;

  localparam int unsigned WORD_BITS_DEFAULT = 16;
  localparam int unsigned OPND_W            = 16;
  localparam int unsigned RES_W             = 32;
  localparam int unsigned FRAC_W            = 4;
  localparam int unsigned FRAC_MAX          = 2 ** FRAC_W - 1;
  localparam logic [FRAC_W-1:0] FRAC_RESET  = 4'd8;
  localparam int unsigned DIV_STEPS         = 4;
  localparam int unsigned FRONT_LAT         = 2;
  localparam int unsigned MUL_LAT           = 2;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [OPND_W-1:0] operand_a;
    logic signed [OPND_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic                    divide_by_zero;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic is_mul;
    logic neg;
    logic dz;
  } ctl_t;

endpackage

// File: rtl/core/fpa_front.sv
// Input register and operand decode stage of the fixed-point ALU.
module fpa_front #(
  parameter int unsigned WORD_BITS = fpa_pkg::WORD_BITS_DEFAULT,
  parameter int unsigned DVD_W     = WORD_BITS + fpa_pkg::FRAC_MAX
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  fpa_pkg::in_item_t              item_i,
  input  logic [fpa_pkg::FRAC_W-1:0]     frac_i,
  output fpa_pkg::ctl_t                  ctl_o,
  output logic [fpa_pkg::RES_W-1:0]      res_o,
  output logic [WORD_BITS-1:0]           mag_a_o,
  output logic [WORD_BITS-1:0]           mag_b_o,
  output logic [DVD_W-1:0]               dvd_o
);

  localparam int unsigned EXT_W = (WORD_BITS > fpa_pkg::OPND_W) ? WORD_BITS : fpa_pkg::OPND_W;

  logic                          valid_q;
  fpa_pkg::in_item_t             item_q;
  logic [fpa_pkg::FRAC_W-1:0]    frac_q;

  logic signed [EXT_W-1:0]       a_ext;
  logic signed [EXT_W-1:0]       b_ext;
  logic [WORD_BITS-1:0]          a;
  logic [WORD_BITS-1:0]          b;
  logic [WORD_BITS-1:0]          sum;
  logic [WORD_BITS-1:0]          diff;
  logic [WORD_BITS-1:0]          ng;
  logic [WORD_BITS-1:0]          mag_a;
  logic [WORD_BITS-1:0]          mag_b;

  fpa_pkg::ctl_t                 ctl_d;
  fpa_pkg::ctl_t                 ctl_q;
  logic [fpa_pkg::RES_W-1:0]     res_d;
  logic [fpa_pkg::RES_W-1:0]     res_q;
  logic [WORD_BITS-1:0]          mag_a_q;
  logic [WORD_BITS-1:0]          mag_b_q;
  logic [DVD_W-1:0]              dvd_d;
  logic [DVD_W-1:0]              dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      valid_q <= accept_i;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_i;
    frac_q  <= frac_i;
    res_q   <= res_d;
    mag_a_q <= mag_a;
    mag_b_q <= mag_b;
    dvd_q   <= dvd_d;
  end

  assign a_ext = EXT_W'($signed(item_q.operand_a));
  assign b_ext = EXT_W'($signed(item_q.operand_b));
  assign a     = a_ext[WORD_BITS-1:0];
  assign b     = b_ext[WORD_BITS-1:0];
  assign sum   = a + b;
  assign diff  = a - b;
  assign ng    = '0 - a;
  assign mag_a = a[WORD_BITS-1] ? ('0 - a) : a;
  assign mag_b = b[WORD_BITS-1] ? ('0 - b) : b;
  assign dvd_d = DVD_W'(mag_a) << frac_q;

  always_comb begin
    fpa_pkg::cmd_e cmd;
    cmd        = fpa_pkg::cmd_e'(item_q.command);
    ctl_d      = '0;
    ctl_d.valid = valid_q;
    ctl_d.neg  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    res_d      = '0;
    case (cmd)
      fpa_pkg::CMD_ADD: res_d = fpa_pkg::RES_W'($signed(sum));
      fpa_pkg::CMD_SUB: res_d = fpa_pkg::RES_W'($signed(diff));
      fpa_pkg::CMD_MUL: ctl_d.is_mul = 1'b1;
      fpa_pkg::CMD_DIV: begin
        ctl_d.is_div = 1'b1;
        ctl_d.dz     = (b == '0);
      end
      fpa_pkg::CMD_NEG: res_d = fpa_pkg::RES_W'($signed(ng));
      default: res_d = '0;
    endcase
  end

  assign ctl_o   = ctl_q;
  assign res_o   = res_q;
  assign mag_a_o = mag_a_q;
  assign mag_b_o = mag_b_q;
  assign dvd_o   = dvd_q;

endmodule

// File: rtl/core/fpa_mul.sv
// Two-stage magnitude multiplier with re-signing of the product.
module fpa_mul #(
  parameter int unsigned WORD_BITS = fpa_pkg::WORD_BITS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic [WORD_BITS-1:0]      mag_a_i,
  input  logic [WORD_BITS-1:0]      mag_b_i,
  input  logic                      neg_i,
  output logic [fpa_pkg::RES_W-1:0] res_o
);

  localparam int unsigned P_W  = 2 * WORD_BITS;
  localparam int unsigned PX_W = (P_W > fpa_pkg::RES_W) ? P_W : fpa_pkg::RES_W;

  logic [P_W-1:0]              prod_q;
  logic                        neg_q;
  logic [P_W-1:0]              sprod;
  logic signed [PX_W-1:0]      prod_ext;
  logic [fpa_pkg::RES_W-1:0]   res_q;

  assign sprod    = neg_q ? ('0 - prod_q) : prod_q;
  assign prod_ext = PX_W'($signed(sprod));

  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(mag_a_i) * P_W'(mag_b_i);
    neg_q  <= neg_i;
    res_q  <= prod_ext[fpa_pkg::RES_W-1:0];
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/fpa_div_stage.sv
// One pipeline stage of the restoring divider, several quotient bits per stage.
module fpa_div_stage #(
  parameter int unsigned WORD_BITS = fpa_pkg::WORD_BITS_DEFAULT,
  parameter int unsigned DVD_W     = WORD_BITS + fpa_pkg::FRAC_MAX
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fpa_pkg::ctl_t             ctl_i,
  input  logic [fpa_pkg::RES_W-1:0] res_i,
  input  logic [WORD_BITS-1:0]      rem_i,
  input  logic [DVD_W-1:0]          dvd_i,
  input  logic [WORD_BITS-1:0]      dsr_i,
  output fpa_pkg::ctl_t             ctl_o,
  output logic [fpa_pkg::RES_W-1:0] res_o,
  output logic [WORD_BITS-1:0]      rem_o,
  output logic [DVD_W-1:0]          dvd_o,
  output logic [WORD_BITS-1:0]      dsr_o
);

  logic [WORD_BITS-1:0]      rem_d;
  logic [DVD_W-1:0]          dvd_d;
  logic [WORD_BITS:0]        cand;

  fpa_pkg::ctl_t             ctl_q;
  logic [fpa_pkg::RES_W-1:0] res_q;
  logic [WORD_BITS-1:0]      rem_q;
  logic [DVD_W-1:0]          dvd_q;
  logic [WORD_BITS-1:0]      dsr_q;

  always_comb begin
    rem_d = rem_i;
    dvd_d = dvd_i;
    cand  = '0;
    for (int s = 0; s < fpa_pkg::DIV_STEPS; s++) begin
      cand  = {rem_d, dvd_d[DVD_W-1]};
      dvd_d = {dvd_d[DVD_W-2:0], 1'b0};
      if (cand >= {1'b0, dsr_i}) begin
        cand     = cand - {1'b0, dsr_i};
        dvd_d[0] = 1'b1;
      end
      rem_d = cand[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_i;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_i;
  end

  assign ctl_o = ctl_q;
  assign res_o = res_q;
  assign rem_o = rem_q;
  assign dvd_o = dvd_q;
  assign dsr_o = dsr_q;

endmodule

// File: rtl/core/fpa_back.sv
// Result selection and output register of the fixed-point ALU.
module fpa_back #(
  parameter int unsigned WORD_BITS = fpa_pkg::WORD_BITS_DEFAULT,
  parameter int unsigned DVD_W     = WORD_BITS + fpa_pkg::FRAC_MAX
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fpa_pkg::ctl_t             ctl_i,
  input  logic [fpa_pkg::RES_W-1:0] res_i,
  input  logic [DVD_W-1:0]          dvd_i,
  output logic                      done_o,
  output fpa_pkg::out_item_t        result_o
);

  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] squo;
  fpa_pkg::out_item_t   out_d;
  fpa_pkg::out_item_t   out_q;
  logic                 done_q;

  assign quo  = dvd_i[WORD_BITS-1:0];
  assign squo = ctl_i.neg ? ('0 - quo) : quo;

  always_comb begin
    out_d.result_value   = res_i;
    out_d.divide_by_zero = 1'b0;
    if (ctl_i.is_div) begin
      out_d.divide_by_zero = ctl_i.dz;
      if (ctl_i.dz) begin
        out_d.result_value = '0;
      end else begin
        out_d.result_value = fpa_pkg::RES_W'($signed(squo));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

// File: rtl/core/fixed_point_twos_complement_alu.sv
// Top level of the pipelined fixed-point two's complement ALU.
// A command transfer happens at a rising edge with start high and busy low; it
// carries the command and two signed operands of WORD_BITS bits in 16-bit fields.
// busy is high only during reset and in the first cycle after it, so a new
// command can be taken in every cycle after that.
// Every command gives one result: done_o is high for exactly one cycle with the
// result on result_o, and the receiver takes it at the end of that cycle.
// Every command runs through the input and decode registers, the divider stages and
// the output register; the pipeline length is set by the restoring divider, which retires four
// quotient bits per stage. Throughput is one command per cycle.
// fraction_bits is written through the cfg channel, which is always ready; write
// it only while no command is in flight. Reset sets it to 8 and empties the pipeline.
// Add, subtract and negate wrap to WORD_BITS bits, multiply gives the signed
// product wrapped to 32 bits, and divide flags a zero divisor and returns zero for it.
module fixed_point_twos_complement_alu #(
  parameter int unsigned WORD_BITS = fpa_pkg::WORD_BITS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  fpa_pkg::in_item_t          in_item_i,
  output logic                       done_o,
  output fpa_pkg::out_item_t         result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fpa_pkg::FRAC_W-1:0] cfg_data_i
);

  localparam int unsigned DVD_W = WORD_BITS + fpa_pkg::FRAC_MAX;
  localparam int unsigned NSTG  = (DVD_W + fpa_pkg::DIV_STEPS - 1) / fpa_pkg::DIV_STEPS;
  localparam int unsigned DWP   = NSTG * fpa_pkg::DIV_STEPS;

  logic                       busy_q;
  logic [fpa_pkg::FRAC_W-1:0] frac_q;
  logic                       accept;

  fpa_pkg::ctl_t              pipe_ctl [0:NSTG];
  logic [fpa_pkg::RES_W-1:0]  pipe_res [0:NSTG];
  logic [WORD_BITS-1:0]       pipe_rem [0:NSTG];
  logic [DWP-1:0]             pipe_dvd [0:NSTG];
  logic [WORD_BITS-1:0]       pipe_dsr [0:NSTG];
  logic [fpa_pkg::RES_W-1:0]  stage_res [0:NSTG-1];
  logic [WORD_BITS-1:0]       mag_a;
  logic [fpa_pkg::RES_W-1:0]  mul_res;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      frac_q <= fpa_pkg::FRAC_RESET;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        frac_q <= cfg_data_i;
      end
    end
  end

  fpa_front #(
    .WORD_BITS(WORD_BITS),
    .DVD_W    (DWP)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .frac_i  (frac_q),
    .ctl_o   (pipe_ctl[0]),
    .res_o   (pipe_res[0]),
    .mag_a_o (mag_a),
    .mag_b_o (pipe_dsr[0]),
    .dvd_o   (pipe_dvd[0])
  );

  assign pipe_rem[0] = '0;

  fpa_mul #(
    .WORD_BITS(WORD_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .mag_a_i(mag_a),
    .mag_b_i(pipe_dsr[0]),
    .neg_i  (pipe_ctl[0].neg),
    .res_o  (mul_res)
  );

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    assign stage_res[k] = (k == fpa_pkg::MUL_LAT && pipe_ctl[k].is_mul) ? mul_res
                                                                           : pipe_res[k];

    fpa_div_stage #(
      .WORD_BITS(WORD_BITS),
      .DVD_W    (DWP)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (pipe_ctl[k]),
      .res_i (stage_res[k]),
      .rem_i (pipe_rem[k]),
      .dvd_i (pipe_dvd[k]),
      .dsr_i (pipe_dsr[k]),
      .ctl_o (pipe_ctl[k+1]),
      .res_o (pipe_res[k+1]),
      .rem_o (pipe_rem[k+1]),
      .dvd_o (pipe_dvd[k+1]),
      .dsr_o (pipe_dsr[k+1])
    );
  end

  fpa_back #(
    .WORD_BITS(WORD_BITS),
    .DVD_W    (DWP)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (pipe_ctl[NSTG]),
    .res_i   (pipe_res[NSTG]),
    .dvd_i   (pipe_dvd[NSTG]),
    .done_o  (done_o),
    .result_o(result_o)
  );

endmodule

// File: rtl/core/fpa_checker.sv
// Port-level assertions of the fixed-point ALU and their bind to the top level.
module fpa_checker #(
  parameter int unsigned WORD_BITS = fpa_pkg::WORD_BITS_DEFAULT
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input fpa_pkg::in_item_t  in_item_i,
  input logic               done_o,
  input fpa_pkg::out_item_t result_o
);

  localparam int unsigned NSTG =
    (WORD_BITS + fpa_pkg::FRAC_MAX + fpa_pkg::DIV_STEPS - 1) / fpa_pkg::DIV_STEPS;
  localparam int unsigned LAT  = fpa_pkg::FRONT_LAT + NSTG + 1;

  logic xfer;
  assign xfer = start && !busy;

  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> ##LAT done_o)
    else $error("Command transfer did not give a result at fixed latency.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(xfer, LAT))
    else $error("Result strobe does not match a command transfer at fixed latency.");

  a_dz_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.divide_by_zero) |->
      $past(xfer && in_item_i.command == fpa_pkg::CMD_DIV, LAT))
    else $error("Divide-by-zero flag on a result that did not come from a divide.");

  a_unknown_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(xfer && in_item_i.command > fpa_pkg::CMD_NEG, LAT)) |->
      (result_o.result_value == '0 && !result_o.divide_by_zero))
    else $error("Unknown command did not give a zero result.");

endmodule

bind fixed_point_twos_complement_alu fpa_checker #(
  .WORD_BITS(WORD_BITS)
) u_fpa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .in_item_i(in_item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
